FILE: design/b2d_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds the field widths, the digit count arithmetic and the controller/datapath structs.
// Depends on nothing.

package b2d_pkg;

   // Fixed widths of the request and response fields.
   localparam int VALUE_W = 64;
   localparam int DIGIT_W = 6;

   // Default width of the converted value.
   localparam int DEFAULT_VALUE_BITS = 64;

   // log10(2) as a ratio. It is used to size the BCD register at elaboration.
   localparam int LOG2_NUM = 30103;
   localparam int LOG2_DEN = 100000;

   // The ASCII code for '0' is 6'b110000. A digit 0..9 fills the low four bits.
   localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request value and clear the BCD register
      logic shift;     // one add-3 and shift step of the conversion
      logic skip;      // drop a leading zero digit
      logic pop;       // move the top digit into the response register
      logic pop_last;  // the digit being popped ends the run
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic top_zero;  // the most significant BCD digit is zero
   } sts_type;

endpackage

FILE: design/b2d_datapath.sv
// Datapath of the binary to decimal ASCII converter: the binary and BCD shift
// registers for the add-3 conversion and the response payload register.
// Depends on b2d_pkg.

module b2d_datapath import b2d_pkg::*; #(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic               clock,
   input  logic [VALUE_W-1:0] req_value,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic [DIGIT_W-1:0] rsp_digit_char,
   output logic               rsp_last
);

   localparam int DIGIT_SLOTS = (VALUE_BITS * LOG2_NUM) / LOG2_DEN + 1;
   localparam int BCD_W       = 4 * DIGIT_SLOTS;

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      bcd_adj;
   logic [DIGIT_W-1:0]    digit_ff, digit_in;
   logic                  last_ff, last_in;
   logic [3:0]            top_digit;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   // Every digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      digit_in = digit_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         bin_in = req_value[VALUE_BITS-1:0];
         bcd_in = '0;
      end else if (cmd.shift) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
      end else if (cmd.skip || cmd.pop) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
      if (cmd.pop) begin
         digit_in = {ASCII_ZERO_HI, top_digit};
         last_in  = cmd.pop_last;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      digit_ff <= digit_in;
      last_ff  <= last_in;
   end

   assign sts.top_zero   = (top_digit == 4'd0);
   assign rsp_digit_char = digit_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: design/b2d_ctrl.sv
// Controller of the binary to decimal ASCII converter: sequences the conversion,
// the leading zero skip and the digit output, and owns the response valid.
// Depends on b2d_pkg.

module b2d_ctrl import b2d_pkg::*; #(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam int DIGIT_SLOTS = (VALUE_BITS * LOG2_NUM) / LOG2_DEN + 1;
   localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
   localparam int DIG_CNT_W   = $clog2(DIGIT_SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 one_left;

   assign one_left = (dig_cnt_ff == DIG_CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS - 1);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_CNT_W'(DIGIT_SLOTS);
               state_in   = ST_SKIP;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_SKIP: begin
            // The least significant digit is always sent, even when it is zero.
            if (sts.top_zero && !one_left) begin
               cmd.skip   = 1'b1;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.pop      = 1'b1;
               cmd.pop_last = one_left;
               rsp_valid_in = 1'b1;
               dig_cnt_in   = dig_cnt_ff - 1'b1;
               if (one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         dig_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // No request is taken while reset is held.
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, top level. Depends on b2d_pkg, b2d_ctrl
// and b2d_datapath.
//
// A request carries one unsigned value on req_value; only its low VALUE_BITS
// bits count. Each request yields one response per decimal digit, most
// significant first, with no leading zeros (zero gives a single '0').
// rsp_digit_char is the ASCII code of the digit and rsp_last marks the final one.
// Requests are handled one at a time. After a request is taken, the add-3 and
// shift loop runs VALUE_BITS times, then each leading zero digit is dropped in
// turn, then one digit leaves per cycle while rsp_ready is high.
// With no stall, the time one request takes is the same whatever the value.
// req_ready rises again once the last digit sits in the response register, so
// the next request may be taken while that digit waits. A stall on rsp_ready
// holds the current digit and halts the output sequence.
// Reset is synchronous and active high; it drops both ready and valid and
// returns the controller to idle.

module binary_to_decimal_ascii import b2d_pkg::*; #(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DIGIT_W-1:0] rsp_digit_char,
   output logic               rsp_last
);

   cmd_type cmd;
   sts_type sts;

   b2d_ctrl #(
      .VALUE_BITS(VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   b2d_datapath #(
      .VALUE_BITS(VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .req_value      (req_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

`ifndef ASSERT_OFF
   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

   // While idle, any response still waiting must be the final digit of its run.
   assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) |-> rsp_last)
      else $error("idle with an unfinished digit run");

   // A response that is shown always carries an ASCII decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char[DIGIT_W-1 -: 2] == ASCII_ZERO_HI
                     && rsp_digit_char[3:0] <= 4'd9))
      else $error("response digit out of range");
`endif

endmodule

FILE: sim/binary_to_decimal_ascii_tb.sv
// Testbench for binary_to_decimal_ascii: drives values and checks each ASCII digit and last flag.
// Depends on b2d_pkg and the binary_to_decimal_ascii RTL. Stimulus and idling are random.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_tb import b2d_pkg::*; ();

   localparam int VALUE_BITS = DEFAULT_VALUE_BITS;
   localparam logic [VALUE_W-1:0] VALUE_MASK =
      (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
   localparam logic [DIGIT_W-1:0] CHAR_ZERO = 6'd48;
   localparam int RANDOM_VALUES = 243;
   localparam int QUIET_ITEMS = 30;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit_char;
      logic               last;
   } digit_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [DIGIT_W-1:0] rsp_digit_char;
   logic               rsp_last;

   logic [VALUE_W-1:0] values_to_send [$];
   digit_type          digits_due [$];
   logic               req_taken = 1'b0;
   logic               req_ready_idle = 1'b0;
   logic               req_hold = 1'b0;
   int                 req_gap = 0;
   int                 rsp_stall = 0;
   int                 bad_digits = 0;

   binary_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // Decimal digits of the masked value, most significant first, no leading zeros.
   function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      logic [3:0]         decimal [$];
      digit_type          digit;
      rest = value & VALUE_MASK;
      do begin
         decimal.push_front(4'(rest % 64'd10));
         rest = rest / 64'd10;
      end while (rest != 0);
      foreach (decimal[k]) begin
         digit.digit_char = CHAR_ZERO + DIGIT_W'(decimal[k]);
         digit.last = (k == decimal.size() - 1);
         digits_due.push_back(digit);
      end
   endfunction

   // Request driver. Besides plain gaps, it sometimes waits until the block
   // is ready and idle, so that a gap also lands where the block sits waiting.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap == 0 && !req_hold && values_to_send.size() > QUIET_ITEMS) begin
            case ($urandom_range(0, 5))
               0: req_gap = $urandom_range(1, 5);
               1: req_hold = 1'b1;
               default: ;
            endcase
         end
         if (req_hold && req_ready_idle) begin
            req_hold = 1'b0;
            req_gap = $urandom_range(1, 5);
         end
         if (req_hold || req_gap != 0) begin
            req_valid <= 1'b0;
            if (!req_hold) req_gap = req_gap - 1;
         end else if (values_to_send.size() != 0) begin
            req_valid <= 1'b1;
            req_value <= values_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_stall == 0 && values_to_send.size() > QUIET_ITEMS && $urandom_range(0, 4) == 0)
            rsp_stall = $urandom_range(1, 5);
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall = rsp_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      digit_type want;
      req_taken <= req_valid && req_ready;
      req_ready_idle <= req_ready && !req_valid;
      if (!reset) begin
         if (req_valid && req_ready) queue_decimal_digits(req_value);
         if (rsp_valid && rsp_ready) begin
            if (digits_due.size() == 0) begin
               bad_digits = bad_digits + 1;
               if (bad_digits <= MAX_REPORTS)
                  $display("%0t: unexpected digit char=%0d last=%0b",
                           $realtime, rsp_digit_char, rsp_last);
            end else begin
               want = digits_due.pop_front();
               if (rsp_digit_char !== want.digit_char || rsp_last !== want.last) begin
                  bad_digits = bad_digits + 1;
                  if (bad_digits <= MAX_REPORTS)
                     $display({"%0t: digit mismatch: expected char=%0d last=%0b, ",
                               "got char=%0d last=%0b"},
                              $realtime, want.digit_char, want.last,
                              rsp_digit_char, rsp_last);
               end
            end
         end
      end
   end

   initial begin
      logic [VALUE_W-1:0] value;
      int                 width;
      // Zero, digit and length boundaries, the 20-digit range and alternating bit patterns.
      values_to_send = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1000,
                         64'd4294967295, 64'd4294967296, 64'h7FFF_FFFF_FFFF_FFFF,
                         64'h8000_0000_0000_0000, 64'd9999999999999999999,
                         64'd10000000000000000000, 64'd12345678901234567890,
                         64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                         64'hFFFF_FFFF_FFFF_FFFF};
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         case ($urandom_range(0, 3))
            0: value = {$urandom, $urandom};
            1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: begin
               width = $urandom_range(1, 19);
               value = VALUE_W'($urandom_range(1, 9));
               for (int k = 1; k < width; k++)
                  value = value * 64'd10 + VALUE_W'($urandom_range(0, 9));
            end
            default: begin
               // Near a power of ten, where the digit count changes.
               width = $urandom_range(0, 19);
               value = 64'd1;
               for (int k = 0; k < width; k++) value = value * 64'd10;
               value = value + VALUE_W'($urandom_range(0, 2)) - 64'd1;
            end
         endcase
         values_to_send.push_back(value);
      end
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (values_to_send.size() != 0 || req_valid) @(posedge clock);
      while (digits_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (bad_digits == 0 && digits_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
